>>> rtl/core/sgr_pkg.sv
// Shared types and constants for the SGR attribute decoder.
package sgr_pkg;

    localparam int unsigned CodeW = 10;
    localparam int unsigned ProdW = 14;
    localparam logic [CodeW-1:0] CodeMax = 10'd1023;

    localparam logic [7:0] ChDigit0 = 8'h30;
    localparam logic [7:0] ChDigit9 = 8'h39;
    localparam logic [7:0] ChSemi   = 8'h3B;

    // Select graphic rendition codes
    localparam logic [CodeW-1:0] SgrReset      = 10'd0;
    localparam logic [CodeW-1:0] SgrBold       = 10'd1;
    localparam logic [CodeW-1:0] SgrFaint      = 10'd2;
    localparam logic [CodeW-1:0] SgrItalic     = 10'd3;
    localparam logic [CodeW-1:0] SgrUnder      = 10'd4;
    localparam logic [CodeW-1:0] SgrExtSel     = 10'd5;
    localparam logic [CodeW-1:0] SgrHidden     = 10'd8;
    localparam logic [CodeW-1:0] SgrStrike     = 10'd9;
    localparam logic [CodeW-1:0] SgrBoldOff    = 10'd21;
    localparam logic [CodeW-1:0] SgrNormal     = 10'd22;
    localparam logic [CodeW-1:0] SgrItalicOff  = 10'd23;
    localparam logic [CodeW-1:0] SgrUnderOff   = 10'd24;
    localparam logic [CodeW-1:0] SgrReveal     = 10'd28;
    localparam logic [CodeW-1:0] SgrStrikeOff  = 10'd29;
    localparam logic [CodeW-1:0] SgrFgBase     = 10'd30;
    localparam logic [CodeW-1:0] SgrFgExt      = 10'd38;
    localparam logic [CodeW-1:0] SgrFgDefault  = 10'd39;
    localparam logic [CodeW-1:0] SgrBgBase     = 10'd40;
    localparam logic [CodeW-1:0] SgrBgExt      = 10'd48;
    localparam logic [CodeW-1:0] SgrBgDefault  = 10'd49;
    localparam logic [CodeW-1:0] SgrOver       = 10'd53;
    localparam logic [CodeW-1:0] SgrOverOff    = 10'd55;
    localparam logic [CodeW-1:0] PaletteMax    = 10'd255;

    localparam logic [1:0] AlphaOpaque = 2'd0;
    localparam logic [1:0] AlphaHalf   = 2'd1;
    localparam logic [1:0] AlphaHidden = 2'd2;

    localparam int unsigned FlBold   = 0;
    localparam int unsigned FlItalic = 1;
    localparam int unsigned FlUnder  = 2;
    localparam int unsigned FlOver   = 3;
    localparam int unsigned FlStrike = 4;

    typedef enum logic [2:0] {
        EXT_IDLE  = 3'b001,
        EXT_ARMED = 3'b010,
        EXT_INDEX = 3'b100
    } t_ext_mode;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_sgr_in;

    typedef struct packed {
        logic [7:0] fg_index;
        logic [1:0] fg_alpha;
        logic [7:0] bg_index;
        logic       bg_on;
        logic       bold;
        logic       italic;
        logic       underline;
        logic       overline;
        logic       strikethrough;
    } t_sgr_out;

endpackage

>>> rtl/core/ansi_sgr_attribute_decoder_core.sv
// Top level of the SGR attribute decoder: parser, attribute state and result register.

// The decoder takes one character of an SGR parameter string per transfer and returns one
// attribute word per character, reflecting the state after that character. The character
// decode, the decimal accumulate and the code apply are one short combinational pass into the
// state and result registers, so a new character is accepted in every cycle while the result
// register is empty or being drained. The result is valid in the cycle after the input
// transfer.
module ansi_sgr_attribute_decoder_core import sgr_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_sgr_in  i_in,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_sgr_out o_out
);

    logic [CodeW-1:0] r_acc, n_acc;
    t_ext_mode        r_fg_mode, n_fg_mode;
    t_ext_mode        r_bg_mode, n_bg_mode;
    logic [7:0]       r_fg, n_fg;
    logic [1:0]       r_fg_alpha, n_fg_alpha;
    logic [7:0]       r_bg, n_bg;
    logic             r_bg_on, n_bg_on;
    logic [4:0]       r_flags, n_flags;
    logic             r_out_valid;
    t_sgr_out         r_out, n_out;

    logic             in_xfer;
    logic             is_digit;
    logic [ProdW-1:0] prod;
    logic [CodeW-1:0] code;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_xfer     = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign is_digit = (i_in.ch >= ChDigit0) && (i_in.ch <= ChDigit9);
    assign prod     = ProdW'(r_acc) * ProdW'(10) + ProdW'(i_in.ch - ChDigit0);
    assign code     = r_acc;

    always_comb begin
        n_acc      = r_acc;
        n_fg_mode  = r_fg_mode;
        n_bg_mode  = r_bg_mode;
        n_fg       = r_fg;
        n_fg_alpha = r_fg_alpha;
        n_bg       = r_bg;
        n_bg_on    = r_bg_on;
        n_flags    = r_flags;

        if (is_digit) begin
            n_acc = (prod > ProdW'(CodeMax)) ? CodeMax : prod[CodeW-1:0];
        end else if (i_in.ch == ChSemi || i_in.last) begin
            n_acc = '0;
            // Pending extended indices win over everything, then the "5" selector.
            if (r_fg_mode == EXT_INDEX) begin
                if (code <= PaletteMax) begin
                    n_fg       = code[7:0];
                    n_fg_alpha = AlphaOpaque;
                end
                n_fg_mode = EXT_IDLE;
            end else if (r_bg_mode == EXT_INDEX) begin
                if (code <= PaletteMax) begin
                    n_bg    = code[7:0];
                    n_bg_on = 1'b1;
                end
                n_bg_mode = EXT_IDLE;
            end else if (r_fg_mode == EXT_ARMED && code == SgrExtSel) begin
                n_fg_mode = EXT_INDEX;
            end else if (r_bg_mode == EXT_ARMED && code == SgrExtSel) begin
                n_bg_mode = EXT_INDEX;
            end else if (code >= SgrFgBase && code < SgrFgExt) begin
                n_fg       = 8'(code - SgrFgBase);
                n_fg_alpha = AlphaOpaque;
            end else if (code >= SgrBgBase && code < SgrBgExt) begin
                n_bg    = 8'(code - SgrBgBase);
                n_bg_on = 1'b1;
            end else begin
                case (code)
                    SgrReset: begin
                        n_fg       = '0;
                        n_fg_alpha = AlphaOpaque;
                        n_bg       = '0;
                        n_bg_on    = 1'b0;
                        n_flags    = '0;
                    end
                    SgrBold:      n_flags[FlBold]   = 1'b1;
                    SgrBoldOff:   n_flags[FlBold]   = 1'b0;
                    SgrFaint:     n_fg_alpha        = AlphaHalf;
                    SgrNormal:    n_fg_alpha        = AlphaOpaque;
                    SgrItalic:    n_flags[FlItalic] = 1'b1;
                    SgrItalicOff: n_flags[FlItalic] = 1'b0;
                    SgrUnder:     n_flags[FlUnder]  = 1'b1;
                    SgrUnderOff:  n_flags[FlUnder]  = 1'b0;
                    SgrHidden:    n_fg_alpha        = AlphaHidden;
                    SgrReveal:    n_fg_alpha        = AlphaOpaque;
                    SgrStrike:    n_flags[FlStrike] = 1'b1;
                    SgrStrikeOff: n_flags[FlStrike] = 1'b0;
                    SgrOver:      n_flags[FlOver]   = 1'b1;
                    SgrOverOff:   n_flags[FlOver]   = 1'b0;
                    SgrFgDefault: begin
                        n_fg       = '0;
                        n_fg_alpha = AlphaOpaque;
                    end
                    SgrBgDefault: begin
                        n_bg    = '0;
                        n_bg_on = 1'b0;
                    end
                    SgrFgExt:     n_fg_mode = EXT_ARMED;
                    SgrBgExt:     n_bg_mode = EXT_ARMED;
                    default: ;
                endcase
            end
        end

        // The last character closes the sequence and drops all parse state.
        if (i_in.last) begin
            n_acc     = '0;
            n_fg_mode = EXT_IDLE;
            n_bg_mode = EXT_IDLE;
        end

        n_out.fg_index      = n_fg;
        n_out.fg_alpha      = n_fg_alpha;
        n_out.bg_index      = n_bg_on ? n_bg : 8'd0;
        n_out.bg_on         = n_bg_on;
        n_out.bold          = n_flags[FlBold];
        n_out.italic        = n_flags[FlItalic];
        n_out.underline     = n_flags[FlUnder];
        n_out.overline      = n_flags[FlOver];
        n_out.strikethrough = n_flags[FlStrike];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_fg_mode   <= EXT_IDLE;
            r_bg_mode   <= EXT_IDLE;
            r_fg        <= '0;
            r_fg_alpha  <= AlphaOpaque;
            r_bg        <= '0;
            r_bg_on     <= 1'b0;
            r_flags     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_xfer) begin
                r_acc       <= n_acc;
                r_fg_mode   <= n_fg_mode;
                r_bg_mode   <= n_bg_mode;
                r_fg        <= n_fg;
                r_fg_alpha  <= n_fg_alpha;
                r_bg        <= n_bg;
                r_bg_on     <= n_bg_on;
                r_flags     <= n_flags;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_out <= n_out;
        end
    end

    // Only one extended color can be waiting for its index at a time.
    a_one_index_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_fg_mode == EXT_INDEX && r_bg_mode == EXT_INDEX))
        else $error("both extended color modes expect an index");

    a_last_clears_parse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && i_in.last |=>
            r_acc == '0 && r_fg_mode == EXT_IDLE && r_bg_mode == EXT_IDLE)
        else $error("parse state survived the last character");

    a_bg_masked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.bg_on |-> r_out.bg_index == 8'd0)
        else $error("background index shown while background is off");

    a_alpha_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fg_alpha != 2'd3)
        else $error("foreground opacity holds an undefined code");

endmodule
